// File: rtl/assert_macros.svh
// Assertion helpers, included by llg_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge, disabled while in reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/llg_pkg.sv
// ---------------------------------------------------------------------------
// llg_pkg
// Shared types, constants and arithmetic helpers for the spin integrator.
// ---------------------------------------------------------------------------
package llg_pkg;

    localparam int DW = 32;
    localparam int FB = 28;
    localparam int CW = 5;   // micro-op counter width

    typedef logic signed [DW-1:0] fx_t;

    localparam fx_t FX_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam fx_t FX_MIN = {1'b1, {(DW-1){1'b0}}};

    localparam logic [2:0] REG_COUPLING = 3'd0;
    localparam logic [2:0] REG_STEP     = 3'd1;
    localparam logic [2:0] REG_INIT_X   = 3'd2;
    localparam logic [2:0] REG_INIT_Y   = 3'd3;
    localparam logic [2:0] REG_INIT_Z   = 3'd4;
    localparam logic [2:0] REG_INTERVAL = 3'd5;

    localparam logic [DW-1:0] INIT_SPIN_RESET = 32'd154981285;
    localparam logic [30:0]   STEP_RESET      = 31'd2684354;
    localparam logic [15:0]   INTERVAL_RESET  = 16'd10;

    // Per-cycle command from the controller.
    typedef struct packed {
        logic       load;      // capture field / reload spin
        logic       restart;
        logic       mul;       // run one multiply micro-op
        logic [CW-1:0] op;     // micro-op index within a stage
        logic       stage2;    // second RK stage
        logic       finish;    // unused by the datapath
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
    } dp_sts_t;

    function automatic fx_t sat_add(input fx_t a, input fx_t b);
        logic signed [DW:0] s;
        begin
            s = {a[DW-1], a} + {b[DW-1], b};
            if (s[DW] != s[DW-1]) sat_add = s[DW] ? FX_MIN : FX_MAX;
            else sat_add = s[DW-1:0];
        end
    endfunction

    function automatic fx_t sat_sub(input fx_t a, input fx_t b);
        logic signed [DW:0] s;
        begin
            s = {a[DW-1], a} - {b[DW-1], b};
            if (s[DW] != s[DW-1]) sat_sub = s[DW] ? FX_MIN : FX_MAX;
            else sat_sub = s[DW-1:0];
        end
    endfunction

    // Product rounding: magnitude rounded half up, then signed saturation.
    // A product of two DW-bit magnitudes always fits in q.
    function automatic fx_t fround(input logic [2*DW-1:0] mag, input logic neg);
        logic [2*DW:0] r;
        logic [DW+4:0] q;
        begin
            r = {1'b0, mag} + ((2*DW+1)'(1) << (FB-1));
            q = r[FB +: DW+5];
            if (neg) begin
                if (q > (DW+5)'({1'b1, {(DW-1){1'b0}}})) fround = FX_MIN;
                else fround = fx_t'(-$signed({1'b0, q[DW-1:0]}));
            end else begin
                if (q > (DW+5)'(FX_MAX)) fround = FX_MAX;
                else fround = fx_t'(q[DW-1:0]);
            end
        end
    endfunction

endpackage

// File: rtl/llg_datapath.sv
// ---------------------------------------------------------------------------
// llg_datapath
// Register file and one shared multiplier; runs micro-ops from the controller.
// ---------------------------------------------------------------------------
module llg_datapath import llg_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  dp_cmd_t       cmd,
    output dp_sts_t       sts,
    input  fx_t           field_x,
    input  fx_t           field_y,
    input  fx_t           field_z,
    input  fx_t           coupling,
    input  logic [30:0]   step_size,
    input  fx_t           init_x,
    input  fx_t           init_y,
    input  fx_t           init_z,
    output fx_t           spin_x,
    output fx_t           spin_y,
    output fx_t           spin_z
);

    fx_t s_reg [3];
    fx_t h_reg [3];
    fx_t a_reg [3];   // stage operand (s or s + r1)
    fx_t t_reg [3];   // a x H, then he
    fx_t d_reg [3];   // a x he
    fx_t p_reg;       // first product of a cross term
    fx_t r1_reg [3];
    fx_t mop_a, mop_b, prod;
    logic [2*DW-1:0] mag_reg;
    logic neg_reg, pend_reg;
    logic [CW-1:0] opd_reg;
    logic st2_reg;

    // Micro-ops per stage (0..17): cross(a,H) 0..5, coupling 6..8,
    // cross(a,he) 9..14, step 15..17. Pairs of products feed one difference.
    always_comb begin
        if (cmd.op < 5'd9) begin
            mop_a = coupling;
            mop_b = t_reg[2'(cmd.op - 5'd6)];
        end else begin
            mop_a = d_reg[2'(cmd.op - 5'd15)];
            mop_b = fx_t'({1'b0, step_size});
        end
    end

    // Cross-op ordering: 0:(1,2)-(2,1) 1:(2,0)-(0,2) 2:(0,1)-(1,0); op 2k/9+2k
    // is the first product, 2k+1/10+2k the second; a[i]*b[j] - a[j]*b[i].
    function automatic logic [1:0] ci(input logic [CW-1:0] o, input logic sel);
        logic [1:0] k;
        begin
            k = (o >= 5'd9) ? 2'((o - 5'd9) >> 1) : 2'(o >> 1);
            case (k)
                2'd0:    ci = sel ? 2'd2 : 2'd1;
                2'd1:    ci = sel ? 2'd0 : 2'd2;
                default: ci = sel ? 2'd1 : 2'd0;
            endcase
        end
    endfunction

    fx_t xa, xb, mul_a, mul_b;
    logic sec;
    always_comb begin
        sec = (cmd.op >= 5'd9) ? ~cmd.op[0] : cmd.op[0];
        xa = a_reg[sec ? ci(cmd.op, 1'b1) : ci(cmd.op, 1'b0)];
        xb = (cmd.op < 5'd6) ? h_reg[sec ? ci(cmd.op, 1'b0) : ci(cmd.op, 1'b1)]
                             : t_reg[sec ? ci(cmd.op, 1'b0) : ci(cmd.op, 1'b1)];
        mul_a = (cmd.op < 5'd6 || (cmd.op >= 5'd9 && cmd.op < 5'd15)) ? xa : mop_a;
        mul_b = (cmd.op < 5'd6 || (cmd.op >= 5'd9 && cmd.op < 5'd15)) ? xb : mop_b;
    end

    logic [DW-1:0] ma, mb;
    assign ma = mul_a[DW-1] ? DW'(-mul_a) : DW'(mul_a);
    assign mb = mul_b[DW-1] ? DW'(-mul_b) : DW'(mul_b);

    assign prod = fround(mag_reg, neg_reg);

    // writeback decode of the op in flight
    logic wb_cross, wb_first;
    logic [1:0] wb_k, wb_c, wb_j;
    assign wb_cross = (opd_reg < 5'd6) || (opd_reg >= 5'd9 && opd_reg < 5'd15);
    assign wb_first = (opd_reg >= 5'd9) ? opd_reg[0] : ~opd_reg[0];
    assign wb_k = (opd_reg >= 5'd9) ? 2'((opd_reg - 5'd9) >> 1) : 2'(opd_reg >> 1);
    assign wb_c = 2'(opd_reg - 5'd6);
    assign wb_j = 2'(opd_reg - 5'd15);

    always_ff @(posedge aclk) begin
        // stage 1: magnitude product registered
        mag_reg <= ma * mb;
        neg_reg <= mul_a[DW-1] ^ mul_b[DW-1];
        opd_reg <= cmd.op;
        st2_reg <= cmd.stage2;
        if (cmd.load) begin
            h_reg[0] <= field_x;
            h_reg[1] <= field_y;
            h_reg[2] <= field_z;
            if (cmd.restart) begin
                s_reg[0] <= init_x; s_reg[1] <= init_y; s_reg[2] <= init_z;
                a_reg[0] <= init_x; a_reg[1] <= init_y; a_reg[2] <= init_z;
            end else begin
                a_reg <= s_reg;
            end
        end
        // stage 2: rounded product consumed
        if (pend_reg) begin
            if (wb_cross) begin
                if (wb_first)
                    p_reg <= prod;
                else if (opd_reg < 5'd6)
                    t_reg[wb_k] <= sat_sub(p_reg, prod);
                else
                    d_reg[wb_k] <= sat_sub(p_reg, prod);
            end else if (opd_reg < 5'd9) begin
                t_reg[wb_c] <= sat_add(h_reg[wb_c], prod);
            end else begin
                if (!st2_reg) begin
                    r1_reg[wb_j] <= prod;
                    a_reg[wb_j]  <= sat_add(s_reg[wb_j], prod);
                end else begin
                    s_reg[wb_j] <= sat_add(s_reg[wb_j],
                        (r1_reg[wb_j] & prod) + (fx_t'(r1_reg[wb_j] ^ prod) >>> 1));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= cmd.mul;
        end
    end

    assign sts.mul_done = pend_reg;
    assign spin_x = s_reg[0];
    assign spin_y = s_reg[1];
    assign spin_z = s_reg[2];

endmodule

// File: rtl/llg_ctrl.sv
// ---------------------------------------------------------------------------
// llg_ctrl
// Sequencer: issues both RK stages' micro-ops, each after the prior writeback.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module llg_ctrl import llg_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      start,
    input  logic      restart,
    input  logic      hold,
    input  dp_sts_t   sts,
    output dp_cmd_t   cmd,
    output logic      busy,
    output logic      done
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] op_reg, op_next;
    logic st2_reg, st2_next;

    always_comb begin
        state_next = state_reg;
        op_next = op_reg;
        st2_next = st2_reg;
        cmd = '0;
        cmd.op = op_reg;
        cmd.stage2 = st2_reg;
        cmd.restart = restart;
        done = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cmd.load = 1'b1;
                    op_next = '0;
                    st2_next = 1'b0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                cmd.mul = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (sts.mul_done) begin
                    if (op_reg == 5'd17) begin
                        op_next = '0;
                        if (st2_reg) state_next = ST_DONE;
                        else begin
                            st2_next = 1'b1;
                            state_next = ST_ISSUE;
                        end
                    end else begin
                        op_next = op_reg + 5'd1;
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_DONE: begin
                // wait here while this step emits and the output register is still full
                if (!hold) begin
                    done = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg <= '0;
            st2_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg <= op_next;
            st2_reg <= st2_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

    `ASSERT_IMPL(a_op_range, aclk, aresetn, 1'b1, op_reg <= 5'd17)
    `ASSERT_NEXT(a_issue_wait, aclk, aresetn, state_reg == ST_ISSUE, state_reg == ST_WAIT)
    `ASSERT_NEXT(a_done_idle, aclk, aresetn, state_reg == ST_DONE && !hold, state_reg == ST_IDLE)

endmodule

// File: rtl/llg_spin_heun_step.sv
// ---------------------------------------------------------------------------
// llg_spin_heun_step
// Macrospin LLG integrator: one Heun step per input word.
// ---------------------------------------------------------------------------
// channel   dir  payload
// s_axis    in   field_x/y/z, restart (tuser)
// m_axis    out  spin_x/y/z
// cfg       in   register writes
// Each word goes through a load, 36 multiplies on one shared multiplier (issue then
// writeback each) and a done state before the next word is accepted.
// The step-count remainder runs bit by bit in the shadow of the multiplies.
// Reset loads the initial spin and zeroes the step count.
// The next word is taken while a result waits in the output register;
// a finished step that emits stalls in its done state only while that register is full.
module llg_spin_heun_step import llg_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // field_x, field_y, field_z
    input  logic          s_tuser,   // restart
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,   // spin_x, spin_y, spin_z
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data
);

    fx_t coupling_reg, init_x_reg, init_y_reg, init_z_reg;
    logic [30:0] step_reg;
    logic [15:0] interval_reg, count_reg, dvd_reg;
    logic [16:0] rem_reg, rem_shift;
    logic [4:0] bit_reg;
    logic busy, done, start, emit, hold;
    dp_cmd_t cmd;
    dp_sts_t sts;
    fx_t sx, sy, sz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coupling_reg <= '0;
            step_reg     <= STEP_RESET;
            init_x_reg   <= INIT_SPIN_RESET;
            init_y_reg   <= INIT_SPIN_RESET;
            init_z_reg   <= INIT_SPIN_RESET;
            interval_reg <= INTERVAL_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_COUPLING: coupling_reg <= cfg_data;
                REG_STEP:     step_reg     <= cfg_data[30:0];
                REG_INIT_X:   init_x_reg   <= cfg_data;
                REG_INIT_Y:   init_y_reg   <= cfg_data;
                REG_INIT_Z:   init_z_reg   <= cfg_data;
                REG_INTERVAL: interval_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !busy;
    assign start = s_tvalid && s_tready;

    // step count mod interval, zero interval emits every step
    assign rem_shift = {rem_reg[15:0], dvd_reg[15]};
    assign emit = (interval_reg == 16'd0) || (rem_reg == 17'd0);
    assign hold = emit && m_tvalid && !m_tready;

    llg_ctrl u_ctrl (
        .aclk, .aresetn, .start, .restart(s_tuser), .hold, .sts, .cmd, .busy, .done
    );

    // Reset spin uses the init reset values: datapath starts from a restart-like load.
    logic first_reg;
    llg_datapath u_dp (
        .aclk, .aresetn, .cmd(dp_cmd_t'({cmd.load, cmd.restart | first_reg,
                                         cmd.mul, cmd.op, cmd.stage2, cmd.finish})),
        .sts, .field_x(s_tdata[31:0]), .field_y(s_tdata[63:32]),
        .field_z(s_tdata[95:64]), .coupling(coupling_reg), .step_size(step_reg),
        .init_x((first_reg && !s_tuser) ? INIT_SPIN_RESET : init_x_reg),
        .init_y((first_reg && !s_tuser) ? INIT_SPIN_RESET : init_y_reg),
        .init_z((first_reg && !s_tuser) ? INIT_SPIN_RESET : init_z_reg),
        .spin_x(sx), .spin_y(sy), .spin_z(sz)
    );

    // restoring remainder, one bit per cycle, msb first
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            count_reg <= '0;
            dvd_reg   <= '0;
            rem_reg   <= '0;
            bit_reg   <= '0;
            m_tvalid  <= 1'b0;
        end else begin
            if (start) begin
                first_reg <= 1'b0;
                dvd_reg   <= s_tuser ? 16'd0 : count_reg;
                count_reg <= (s_tuser ? 16'd0 : count_reg) + 16'd1;
                rem_reg   <= '0;
                bit_reg   <= 5'd16;
            end else if (bit_reg != 5'd0) begin
                rem_reg <= (rem_shift >= {1'b0, interval_reg})
                           ? rem_shift - {1'b0, interval_reg} : rem_shift;
                dvd_reg <= {dvd_reg[14:0], 1'b0};
                bit_reg <= bit_reg - 5'd1;
            end
            if (done && emit) m_tvalid <= 1'b1;
            else if (m_tready) m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done && emit) m_tdata <= {sz, sy, sx};
    end

endmodule

// File: tb/llg_spin_heun_step_check.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// llg_spin_heun_step_check
// Watches the field, spin and register ports of the integrator. It keeps its
// own copy of the spin, step counter and registers, works out each expected
// spin in Q3.28, and compares every emitted spin word against it.
// ---------------------------------------------------------------------------
module llg_spin_heun_step_check import llg_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,   // field_x, field_y, field_z
    input  logic        s_tuser,   // restart
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,   // spin_x, spin_y, spin_z
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          steps_seen,
    output int          spins_seen
);

    fx_t         lambda_q;
    fx_t         h_q;
    fx_t         init_q [3];
    logic [15:0] emit_period;
    fx_t         spin_q [3];
    logic [15:0] step_cnt;
    logic [95:0] spin_fifo [$];

    initial begin
        errors = 0;
        steps_seen = 0;
        spins_seen = 0;
    end

    assign pending = spin_fifo.size();

    // exact product, magnitude rounded half up, then clamped
    function automatic fx_t q_mul(input fx_t a, input fx_t b);
        logic signed [63:0] p;
        logic [63:0] m, q;
        begin
            p = 64'(a) * 64'(b);
            m = (p < 0) ? -p : p;
            q = (m + (64'd1 << 27)) >> 28;
            if (p < 0) q_mul = (q > 64'h8000_0000) ? FX_MIN : fx_t'(-q);
            else q_mul = (q > 64'h7fff_ffff) ? FX_MAX : fx_t'(q);
        end
    endfunction

    function automatic fx_t q_add(input fx_t a, input fx_t b);
        logic signed [32:0] s;
        begin
            s = 33'(a) + 33'(b);
            q_add = (s > 33'sd2147483647) ? FX_MAX : (s < -33'sd2147483648) ? FX_MIN : fx_t'(s);
        end
    endfunction

    function automatic fx_t q_sub(input fx_t a, input fx_t b);
        logic signed [32:0] s;
        begin
            s = 33'(a) - 33'(b);
            q_sub = (s > 33'sd2147483647) ? FX_MAX : (s < -33'sd2147483648) ? FX_MIN : fx_t'(s);
        end
    endfunction

    function automatic void q_cross(input fx_t a [3], input fx_t b [3], output fx_t r [3]);
        r[0] = q_sub(q_mul(a[1], b[2]), q_mul(a[2], b[1]));
        r[1] = q_sub(q_mul(a[2], b[0]), q_mul(a[0], b[2]));
        r[2] = q_sub(q_mul(a[0], b[1]), q_mul(a[1], b[0]));
    endfunction

    // h * (s x Heff(s)), Heff = H + lambda * (s x H)
    function automatic void torque_step(input fx_t s [3], input fx_t hf [3],
                                        output fx_t r [3]);
        fx_t t [3], he [3], d [3];
        q_cross(s, hf, t);
        for (int k = 0; k < 3; k++) he[k] = q_add(hf[k], q_mul(lambda_q, t[k]));
        q_cross(s, he, d);
        for (int k = 0; k < 3; k++) r[k] = q_mul(d[k], h_q);
    endfunction

    function automatic void heun_advance(input logic [95:0] fields, input logic rst);
        fx_t hf [3], r1 [3], r2 [3], mid [3];
        logic signed [32:0] sum;
        for (int k = 0; k < 3; k++) hf[k] = fields[32*k +: 32];
        if (rst) begin
            spin_q = init_q;
            step_cnt = '0;
        end
        torque_step(spin_q, hf, r1);
        for (int k = 0; k < 3; k++) mid[k] = q_add(spin_q[k], r1[k]);
        torque_step(mid, hf, r2);
        for (int k = 0; k < 3; k++) begin
            sum = 33'(r1[k]) + 33'(r2[k]);
            spin_q[k] = q_add(spin_q[k], fx_t'(sum >>> 1));
        end
        if (emit_period == 0 || step_cnt % emit_period == 0)
            spin_fifo.push_back({spin_q[2], spin_q[1], spin_q[0]});
        step_cnt = step_cnt + 16'd1;
    endfunction

    always @(posedge aclk) begin
        logic [95:0] want;
        if (!aresetn) begin
            lambda_q = '0;
            h_q = fx_t'({1'b0, STEP_RESET});
            for (int k = 0; k < 3; k++) begin
                init_q[k] = INIT_SPIN_RESET;
                spin_q[k] = INIT_SPIN_RESET;
            end
            emit_period = INTERVAL_RESET;
            step_cnt = '0;
            spin_fifo.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_COUPLING: lambda_q = cfg_data;
                    REG_STEP:     h_q = {1'b0, cfg_data[30:0]};
                    REG_INIT_X:   init_q[0] = cfg_data;
                    REG_INIT_Y:   init_q[1] = cfg_data;
                    REG_INIT_Z:   init_q[2] = cfg_data;
                    REG_INTERVAL: emit_period = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                heun_advance(s_tdata, s_tuser);
                steps_seen++;
            end
            if (m_tvalid && m_tready) begin
                spins_seen++;
                if (spin_fifo.size() == 0) begin
                    errors++;
                    $display("%0t: spin word %h with nothing expected", $time, m_tdata);
                end else begin
                    want = spin_fifo.pop_front();
                    for (int k = 0; k < 3; k++)
                        if (want[32*k +: 32] !== m_tdata[32*k +: 32]) begin
                            errors++;
                            $display("%0t: spin[%0d] expected %h actual %h", $time, k,
                                     want[32*k +: 32], m_tdata[32*k +: 32]);
                        end
                end
            end
        end
    end

endmodule

// File: tb/llg_spin_heun_step_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// llg_spin_heun_step_test
// Drives field words and register writes into the Heun integrator under
// random back-pressure, including a long output hold-off; the checker
// predicts and compares each spin word.
// ---------------------------------------------------------------------------
module llg_spin_heun_step_test import llg_pkg::*; ();

    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam logic [2:0] REG_SPARE  = 3'd7;
    localparam int         IDLE_LIMIT = 50000;
    localparam int         HOLD_CYCLES = 3000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    int errors, pending, steps_seen, spins_seen;
    int snd_idle_pct = 28;
    int rcv_idle_pct = 71;
    bit hold_tog = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;
    int quiet = 0;

    always #5 aclk = ~aclk;

    llg_spin_heun_step dut (.*);

    llg_spin_heun_step_check chk (.*);

    // receiver: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic put_field(input fx_t fx, input fx_t fy, input fx_t fz, input logic rst);
        if ($urandom_range(99) < snd_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < snd_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {fz, fy, fx};
        s_tuser <= rst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // wait until all spins are out and the last step has surely finished
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
    endtask

    task automatic load_regs(input fx_t lam, input logic [31:0] h, input fx_t ix,
                             input fx_t iy, input fx_t iz, input logic [15:0] period);
        write_reg(REG_COUPLING, lam);
        write_reg(REG_STEP, h);
        write_reg(REG_INIT_X, ix);
        write_reg(REG_INIT_Y, iy);
        write_reg(REG_INIT_Z, iz);
        write_reg(REG_INTERVAL, {16'd0, period});
        cfg_we <= 1'b0;
    endtask

    function automatic fx_t pick_val();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6) return fx_t'($signed($urandom_range(32'h3fff_ffff)) - 32'sh2000_0000);
        if (sel < 8) return fx_t'($urandom);
        case ($urandom_range(3))
            0: return FX_MAX;
            1: return FX_MIN;
            2: return '0;
            default: return fx_t'(32'sd1 << 28);
        endcase
    endfunction

    task automatic random_steps(input int n);
        for (int i = 0; i < n; i++)
            put_field(pick_val(), pick_val(), pick_val(), $urandom_range(19) == 0);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values, then corners of the field
        put_field(fx_t'(32'sd1 << 28), '0, '0, 1'b0);
        put_field(FX_MAX, FX_MAX, FX_MAX, 1'b0);
        put_field(FX_MIN, FX_MIN, FX_MIN, 1'b0);
        put_field(FX_MAX, FX_MIN, '0, 1'b1);
        put_field('0, '0, '0, 1'b0);
        put_field(32'sh0000_0001, 32'shffff_ffff, 32'sh0800_0000, 1'b0);
        for (int i = 0; i < 8; i++)
            put_field(pick_val(), pick_val(), pick_val(), i == 4);
        settle();
        write_reg(REG_UNUSED, 32'hffff_ffff);
        write_reg(REG_SPARE, 32'h1234_5678);
        load_regs(32'sh0100_0000, 32'h0100_0000, 32'sh1000_0000, '0, 32'shf000_0000, 16'd1);
        put_field(FX_MAX, FX_MIN, FX_MAX, 1'b1);
        put_field('0, fx_t'(32'sd1 << 28), '0, 1'b0);
        put_field(FX_MIN, '0, FX_MAX, 1'b0);
        put_field(pick_val(), pick_val(), pick_val(), 1'b1);
        settle();

        load_regs(fx_t'($urandom), 32'h0040_0000, pick_val(), pick_val(), pick_val(), 16'd3);
        random_steps(200);
        settle();

        snd_idle_pct = 71;
        rcv_idle_pct = 28;
        load_regs(FX_MIN, 32'h7fff_ffff, FX_MAX, FX_MIN, '0, 16'd0);
        put_field(pick_val(), pick_val(), pick_val(), 1'b1);
        random_steps(150);
        settle();
        load_regs(FX_MAX, 32'h0, pick_val(), pick_val(), pick_val(), 16'hffff);
        put_field(pick_val(), pick_val(), pick_val(), 1'b1);
        random_steps(30);
        settle();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        load_regs(32'sh0080_0000, 32'h0028_f5c2, 32'sh093c_d3a5, 32'sh093c_d3a5,
                  32'sh093c_d3a5, 16'd1);
        put_field(pick_val(), pick_val(), pick_val(), 1'b1);
        hold_tog <= ~hold_tog;
        random_steps(90);
        settle();
        load_regs(fx_t'($urandom), 32'h0010_0000, pick_val(), pick_val(), pick_val(), 16'd2);
        random_steps(90);
        settle();

        $display("steps driven: %0d, spin words checked: %0d, over seven register settings",
                 steps_seen, spins_seen);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
